### hw/rtl/tswt_pkg.sv
// Package: shared types and constants for the tick sleep/wakeup table.
`timescale 1ns / 1ps
package tswt_pkg;
  localparam int unsigned HzW = 21;
  localparam int unsigned MsW = 32;
  localparam int unsigned TickW = 32;
  localparam int unsigned SlotW = 6;
  localparam int unsigned KindW = 2;

  localparam logic [KindW-1:0] KIND_IDLE  = 2'd0;
  localparam logic [KindW-1:0] KIND_WOKEN = 2'd1;
  localparam logic [KindW-1:0] KIND_ARMED = 2'd2;

  localparam logic [TickW-1:0] MAX_SLEEP_TICKS = 32'h7FFF_FFFF;
  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam logic [9:0] ROUND_UP = 10'd999;

  // ceil(2^38 / 1000); exact quotient for any 32-bit dividend
  localparam logic [28:0] DIV_RECIP = 29'h1062_4DD3;
  localparam int unsigned DIV_SHIFT = 38;

  typedef struct packed {
    logic             mode;
    logic [SlotW-1:0] slot;
    logic [MsW-1:0]   duration_ms;
  } in_word_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SlotW-1:0] woken_slot;
    logic [TickW-1:0] deadline;
    logic [TickW-1:0] tick_now;
    logic             last;
  } out_word_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic             is_arm;
    logic [SlotW-1:0] slot;
    logic [TickW-1:0] ticks;
  } cmd_t;
endpackage

### hw/rtl/tswt_if.sv
// Interfaces: valid/ready channels for input and result words.
`timescale 1ns / 1ps
interface tswt_in_if;
  logic                valid;
  logic                ready;
  tswt_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tswt_out_if;
  logic                valid;
  logic                ready;
  tswt_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/tswt_front.sv
// Front end: accepts words and converts sleep lengths to tick counts.
`timescale 1ns / 1ps
module tswt_front #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tswt_pkg::HzW-1:0]      tick_hz,
  tswt_in_if.sink                       in_ch,
  output logic                          cmd_valid,
  output tswt_pkg::cmd_t                cmd,
  input  logic                          cmd_ready
);
  // ms*hz+999 fits 53 bits; divided by 1000 as two 22-bit chunks, each a
  // reciprocal multiply then a remainder pass.
  localparam int unsigned PW = tswt_pkg::MsW + tswt_pkg::HzW;
  localparam int unsigned CKW = 22;
  localparam int unsigned QW = 2 * CKW;
  localparam int unsigned DW = 10 + CKW;
  localparam int unsigned RW = DW + 29;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_DIV = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [PW-1:0] num;
  logic [QW-1:0] quo;
  logic [9:0] rem;
  logic [CKW-1:0] part;
  logic [1:0] step;
  logic [tswt_pkg::SlotW-1:0] slot;
  logic is_arm;
  logic [PW-1:0] prod;
  logic [PW-1:0] num_rnd;
  logic [CKW-1:0] chunk;
  logic [DW-1:0] dvd;
  logic [RW-1:0] recip_prod;
  logic [DW-1:0] part_x;
  logic [DW-1:0] rem_full;
  logic take;

  assign in_ch.ready = (state == S_IDLE);
  assign take = in_ch.valid && in_ch.ready;
  assign prod = PW'(in_ch.data.duration_ms) * PW'(tick_hz);
  assign num_rnd = num + PW'(tswt_pkg::ROUND_UP);
  // high chunk in steps 0 and 1, low chunk in steps 2 and 3
  assign chunk = step[1] ? num[CKW-1:0] : num[QW-1:CKW];
  assign dvd = {rem, chunk};
  assign recip_prod = RW'(dvd) * RW'(tswt_pkg::DIV_RECIP);
  assign part_x = DW'(part) * DW'(tswt_pkg::MS_PER_S);
  assign rem_full = dvd - part_x;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (take) begin
        if (!in_ch.data.mode) state_next = S_OUT;
        else if (32'(in_ch.data.slot) < SLOTS) state_next = S_MUL;
      end
      S_MUL: state_next = S_DIV;
      S_DIV: if (step == 2'd3) state_next = S_OUT;
      S_OUT: if (cmd_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      is_arm <= in_ch.data.mode;
      slot <= in_ch.data.slot;
      num <= prod;
    end
    if (state == S_MUL) begin
      // top 9 bits are below 1000, so they seed the remainder directly
      num <= num_rnd;
      rem <= {1'b0, num_rnd[PW-1:QW]};
      step <= '0;
    end
    if (state == S_DIV) begin
      step <= step + 2'd1;
      if (!step[0]) begin
        part <= recip_prod[tswt_pkg::DIV_SHIFT +: CKW];
      end else begin
        rem <= rem_full[9:0];
        quo <= {quo[CKW-1:0], part};
      end
    end
  end

  always_comb begin
    cmd.is_arm = is_arm;
    cmd.slot = slot;
    if (quo == '0) cmd.ticks = 32'd1;
    else if (quo > QW'(tswt_pkg::MAX_SLEEP_TICKS)) cmd.ticks = tswt_pkg::MAX_SLEEP_TICKS;
    else cmd.ticks = quo[tswt_pkg::TickW-1:0];
  end
  assign cmd_valid = (state == S_OUT);
endmodule

### hw/rtl/tswt_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module tswt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  input  tswt_pkg::cmd_t wr_data,
  output logic           wr_ready,
  output logic           rd_valid,
  output tswt_pkg::cmd_t rd_data,
  input  logic           rd_ready
);
  tswt_pkg::cmd_t mem [2];
  logic wp, rp;
  logic [1:0] fill;
  logic push, pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end
endmodule

### hw/rtl/tswt_back.sv
// Back end: slot table, tick counter, arming and wake scan.
`timescale 1ns / 1ps
module tswt_back #(
  parameter int unsigned SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  tswt_pkg::cmd_t cmd,
  output logic           cmd_ready,
  tswt_out_if.source     out_ch
);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TW = tswt_pkg::TickW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_SCAN = 3'b010, S_EMIT = 3'b100
  } state_t;

  state_t state;
  logic [TW-1:0] dl_mem [SLOTS];
  logic [SLOTS-1:0] armed;
  logic [TW-1:0] tick_count;
  logic [IW-1:0] idx;
  logic [TW-1:0] rd_dl;
  logic rd_ok;      // registered read of idx valid
  logic [IW-1:0] rd_idx;
  logic woke_any;
  logic scan_done;
  logic [TW-1:0] diff;
  logic hit;
  logic out_free;
  logic take;
  logic scan_step;
  logic pend_go;

  // pending result waiting to go into the output register
  logic pend;
  tswt_pkg::out_word_t pend_w;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign cmd_ready = (state == S_IDLE) && !pend;
  assign take = cmd_valid && cmd_ready;
  assign diff = rd_dl - tick_count;
  assign hit = rd_ok && armed[rd_idx] && (diff == '0 || diff[TW-1]);
  assign scan_step = (state == S_SCAN) && (!pend || out_free);
  // a woken word is held until the next wake or the end of the scan settles its last flag
  assign pend_go = pend && out_free && ((state == S_IDLE) || (scan_step && hit));

  always_ff @(posedge clk) begin
    if (scan_step) rd_dl <= dl_mem[idx];
    if (take && cmd.is_arm)
      dl_mem[cmd.slot[IW-1:0]] <= tick_count + cmd.ticks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      armed <= '0;
      tick_count <= '0;
      idx <= '0;
      rd_ok <= 1'b0;
      rd_idx <= '0;
      woke_any <= 1'b0;
      scan_done <= 1'b0;
      pend <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (pend_go) begin
        out_ch.valid <= 1'b1;
        pend <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (take) begin
          if (cmd.is_arm) begin
            armed[cmd.slot[IW-1:0]] <= 1'b1;
            pend <= 1'b1;
          end else begin
            tick_count <= tick_count + 1'b1;
            idx <= '0;
            rd_ok <= 1'b0;
            woke_any <= 1'b0;
            scan_done <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: if (scan_step) begin
          // one slot per cycle unless output stalls; rd_idx result uses its registered read
          if (hit) begin
            armed[rd_idx] <= 1'b0;
            woke_any <= 1'b1;
            pend <= 1'b1;
          end
          rd_ok <= !scan_done;
          rd_idx <= idx;
          if (!scan_done) begin
            if (32'(idx) == SLOTS - 1) scan_done <= 1'b1;
            else idx <= idx + 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!woke_any) pend <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pend_go) out_ch.data <= pend_w;
    unique case (state)
      S_IDLE: if (take && cmd.is_arm) begin
        pend_w.kind <= tswt_pkg::KIND_ARMED;
        pend_w.woken_slot <= cmd.slot;
        pend_w.deadline <= tick_count + cmd.ticks;
        pend_w.tick_now <= tick_count;
        pend_w.last <= 1'b1;
      end
      S_SCAN: if (scan_step && hit) begin
        pend_w.kind <= tswt_pkg::KIND_WOKEN;
        pend_w.woken_slot <= tswt_pkg::SlotW'(rd_idx);
        pend_w.deadline <= rd_dl;
        pend_w.tick_now <= tick_count;
        pend_w.last <= 1'b0;
      end
      S_EMIT: if (!woke_any) begin
        pend_w.kind <= tswt_pkg::KIND_IDLE;
        pend_w.woken_slot <= '0;
        pend_w.deadline <= '0;
        pend_w.tick_now <= tick_count;
        pend_w.last <= 1'b1;
      end else begin
        // held word is the final wake of this tick
        pend_w.last <= 1'b1;
      end
      default: ;
    endcase
  end
endmodule

### hw/rtl/tick_sleep_wakeup_table_top.sv
// Top level: tick sleep/wakeup table.
//
// in_ch carries words {mode, slot, duration_ms}; mode 0 is a timer tick, mode 1
// arms a sleep. out_ch carries result words {kind, woken_slot, deadline,
// tick_now, last}. A tick gives one word per woken slot in ascending order
// (last on the final one), or one kind-0 word if none woke. An arm gives
// one kind-2 word; an arm of a slot beyond SLOTS gives nothing.
// The user must see that tick_hz is written through cfg_we/cfg_data only
// while the block is idle; the block itself does not enforce this. The front
// end forms ms*tick_hz and divides by 1000 (two chunks, reciprocal multiply
// then remainder), taking no new word until it has handed on the current one.
// The back end scans the slot table one entry a cycle while the output does
// not stall, from a single-port deadline memory, and takes no new command
// during a scan. A two-entry queue lets the front convert while the back scans.
// Reset clears the tick counter and all armed flags and restores tick_hz
// to 100. When the receiver stalls, the output register holds its word
// and the scan waits; the front keeps accepting until the queue fills.
`timescale 1ns / 1ps
module tick_sleep_wakeup_table_top #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [tswt_pkg::HzW-1:0] cfg_data,
  tswt_in_if.sink                  in_ch,
  tswt_out_if.source               out_ch
);
  logic [tswt_pkg::HzW-1:0] tick_hz;
  logic f_valid, f_ready, b_valid, b_ready;
  tswt_pkg::cmd_t f_cmd, b_cmd;

  always_ff @(posedge clk) begin
    if (rst) tick_hz <= tswt_pkg::HzW'(100);
    else if (cfg_we) tick_hz <= cfg_data;
  end

  tswt_front #(.SLOTS(SLOTS)) u_front (
    .clk, .rst, .tick_hz, .in_ch,
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
  );

  tswt_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_data(f_cmd), .wr_ready(f_ready),
    .rd_valid(b_valid), .rd_data(b_cmd), .rd_ready(b_ready)
  );

  tswt_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst,
    .cmd_valid(b_valid), .cmd(b_cmd), .cmd_ready(b_ready), .out_ch
  );
endmodule
